FILE: rtl/psd_pkg.sv
// Shared types and constants of the pattern sidechain ducker.
// Holds the register map, control/status structs and the alpha lookup table.
// Depends on nothing.
package psd_pkg;

  localparam int unsigned DATA_W        = 32;
  localparam int unsigned ADDR_W        = 5;
  localparam int unsigned IDX_W         = 3;
  localparam int unsigned PATTERN_SLOTS = 4;
  localparam int unsigned SEL_W         = 2;
  localparam int unsigned WORD_W        = 16;
  localparam int unsigned FRAC_W        = 16;
  localparam int unsigned LEVEL_W       = 7;
  localparam int unsigned STEP_OUT_W    = 4;
  localparam int unsigned ALPHA_W       = 16;
  localparam int unsigned GAIN_W        = 23;
  localparam int unsigned SHEER_N       = 128;
  localparam int unsigned IN_TDATA_W    = 32;
  localparam int unsigned OUT_TDATA_W   = 16;

  localparam logic [LEVEL_W-1:0]   LEVEL_MAX = 7'd127;
  localparam logic [ALPHA_W:0]     ALPHA_ONE = 17'h10000;

  // Register indexes (byte address / 4)
  localparam logic [IDX_W-1:0] REG_SEL   = 3'd0;
  localparam logic [IDX_W-1:0] REG_WORD0 = 3'd1;
  localparam logic [IDX_W-1:0] REG_WORD1 = 3'd2;
  localparam logic [IDX_W-1:0] REG_WORD2 = 3'd3;
  localparam logic [IDX_W-1:0] REG_WORD3 = 3'd4;

  typedef logic [ALPHA_W-1:0] alpha_t;
  typedef alpha_t [SHEER_N-1:0] alpha_tbl_t;

  typedef struct packed {
    logic                                   sel_wr;
    logic [SEL_W-1:0]                       sel;
    logic [PATTERN_SLOTS-1:0][WORD_W-1:0]   word;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic step_en;
    logic mul_en;
    logic sum_en;
  } cmd_t;

  typedef struct packed {
    logic step_same;
    logic pattern_ok;
    logic out_free;
  } status_t;

  // Piecewise-linear alpha in Q16, rounded to nearest from the exact ratio
  function automatic alpha_tbl_t build_alpha_table();
    alpha_tbl_t tbl;
    longint     num;
    for (int s = 0; s < SHEER_N; s++) begin
      if (s < 32) begin
        num = 64'd65536 * (32 + 9 * s);
        tbl[s] = ALPHA_W'((num + 1600) / 3200);
      end else if (s < 96) begin
        num = 64'd65536 * (64 + 3 * (s - 32));
        tbl[s] = ALPHA_W'((num + 320) / 640);
      end else begin
        num = 64'd65536 * (1240 + 59 * (s - 96));
        tbl[s] = ALPHA_W'((num + 1550) / 3100);
      end
    end
    return tbl;
  endfunction

  localparam alpha_tbl_t ALPHA_TABLE = build_alpha_table();

endpackage

FILE: rtl/psd_regs.sv
// APB register file of the pattern sidechain ducker: pattern select and
// the four gate pattern words. Depends on psd_pkg.
module psd_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psd_pkg::ADDR_W-1:0]    paddr,
  input  logic [psd_pkg::DATA_W-1:0]    pwdata,
  output logic [psd_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output psd_pkg::cfg_t                 cfg_o
);

  logic [psd_pkg::SEL_W-1:0]                             sel_q, sel_d;
  logic [psd_pkg::PATTERN_SLOTS-1:0][psd_pkg::WORD_W-1:0] word_q, word_d;
  logic [psd_pkg::IDX_W-1:0]                             idx;
  logic                                                  wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[psd_pkg::ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    sel_d  = sel_q;
    word_d = word_q;
    if (wr_en) begin
      case (idx)
        psd_pkg::REG_SEL:   sel_d     = pwdata[psd_pkg::SEL_W-1:0];
        psd_pkg::REG_WORD0: word_d[0] = pwdata[psd_pkg::WORD_W-1:0];
        psd_pkg::REG_WORD1: word_d[1] = pwdata[psd_pkg::WORD_W-1:0];
        psd_pkg::REG_WORD2: word_d[2] = pwdata[psd_pkg::WORD_W-1:0];
        psd_pkg::REG_WORD3: word_d[3] = pwdata[psd_pkg::WORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q  <= '0;
      word_q <= '0;
    end else begin
      sel_q  <= sel_d;
      word_q <= word_d;
    end
  end

  always_comb begin
    case (idx)
      psd_pkg::REG_SEL:   prdata = psd_pkg::DATA_W'(sel_q);
      psd_pkg::REG_WORD0: prdata = psd_pkg::DATA_W'(word_q[0]);
      psd_pkg::REG_WORD1: prdata = psd_pkg::DATA_W'(word_q[1]);
      psd_pkg::REG_WORD2: prdata = psd_pkg::DATA_W'(word_q[2]);
      psd_pkg::REG_WORD3: prdata = psd_pkg::DATA_W'(word_q[3]);
      default:            prdata = '0;
    endcase
  end

  // Any write to the select register restarts step tracking
  assign cfg_o.sel_wr = wr_en && (idx == psd_pkg::REG_SEL);
  assign cfg_o.sel    = sel_q;
  assign cfg_o.word   = word_q;

endmodule

FILE: rtl/psd_ctrl.sv
// Sequencer of the pattern sidechain ducker: one-hot state machine that
// steps the datapath through step, multiply and sum. Depends on psd_pkg.
module psd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  psd_pkg::status_t  status_i,
  output psd_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_STEP = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_SUM  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_STEP;
        end
      end
      ST_STEP: begin
        cmd_o.step_en = 1'b1;
        // drop the word when the step holds or the pattern is absent
        if (status_i.step_same || !status_i.pattern_ok) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        if (status_i.out_free) begin
          cmd_o.sum_en = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/psd_dpath.sv
// Datapath of the pattern sidechain ducker: step derivation, gate lookup,
// alpha blend of the smoothed level and the output register. Depends on psd_pkg.
module psd_dpath #(
  parameter int unsigned STEP_COUNT    = 16,
  parameter int unsigned PATTERN_COUNT = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  psd_pkg::cmd_t                     cmd_i,
  output psd_pkg::status_t                  status_o,
  input  psd_pkg::cfg_t                     cfg_i,
  input  logic [psd_pkg::FRAC_W-1:0]        frac_i,
  input  logic [psd_pkg::LEVEL_W-1:0]       depth_i,
  input  logic [psd_pkg::LEVEL_W-1:0]       sheer_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [psd_pkg::LEVEL_W-1:0]       level_o,
  output logic [psd_pkg::STEP_OUT_W-1:0]    step_o
);

  localparam int unsigned SW   = $clog2(STEP_COUNT);
  localparam int unsigned PW   = $clog2(4 * STEP_COUNT + 1);
  localparam int unsigned MW   = psd_pkg::FRAC_W + PW;
  localparam int unsigned PA_W = psd_pkg::ALPHA_W + psd_pkg::LEVEL_W;
  localparam int unsigned PB_W = psd_pkg::ALPHA_W + 1 + psd_pkg::GAIN_W;
  localparam int unsigned AC_W = PB_W + 1;

  logic [psd_pkg::FRAC_W-1:0]   frac_q;
  logic [psd_pkg::LEVEL_W-1:0]  depth_q;
  logic [psd_pkg::LEVEL_W-1:0]  sheer_q;
  logic [SW-1:0]                step_q, step_d;
  logic [SW-1:0]                prev_step_q;
  logic                         prev_valid_q, prev_valid_d;
  logic [psd_pkg::ALPHA_W-1:0]  alpha_q;
  logic [PA_W-1:0]              prod_a_q;
  logic [PB_W-1:0]              prod_b_q;
  logic [psd_pkg::GAIN_W-1:0]   gain_q, gain_d;
  logic                         out_valid_q, out_valid_d;
  logic [psd_pkg::LEVEL_W-1:0]  level_q, level_d;
  logic [psd_pkg::STEP_OUT_W-1:0] step_out_q;

  logic [MW-1:0]                scaled_full;
  logic [PW-1:0]                wrap;
  logic [psd_pkg::WORD_W-1:0]   word;
  logic                         gate;
  logic [psd_pkg::LEVEL_W-1:0]  target;
  logic [AC_W-1:0]              acc;
  logic [psd_pkg::GAIN_W:0]     rounded;
  logic [psd_pkg::GAIN_W-psd_pkg::FRAC_W:0] level_wide;

  // Step: (floor(4*N*frac / 2^16) + 1) mod N, wrapped by repeated subtraction
  always_comb begin
    scaled_full = MW'(frac_q) * MW'(4 * STEP_COUNT);
    wrap        = scaled_full[MW-1:psd_pkg::FRAC_W] + PW'(1);
    for (int i = 0; i < 4; i++) begin
      if (wrap >= PW'(STEP_COUNT)) begin
        wrap = wrap - PW'(STEP_COUNT);
      end
    end
    step_d = SW'(wrap);
  end

  assign status_o.step_same  = prev_valid_q && (step_d == prev_step_q);
  assign status_o.pattern_ok = ({1'b0, cfg_i.sel} < 3'(PATTERN_COUNT));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // Gate lookup: steps past the pattern word read as gate off
  assign word   = cfg_i.word[cfg_i.sel];
  assign gate   = ((step_q >> 4) == '0) && word[4'(step_q)];
  assign target = gate ? psd_pkg::LEVEL_MAX : (psd_pkg::LEVEL_MAX - depth_q);

  // Blend and round
  assign acc        = AC_W'({prod_a_q, psd_pkg::FRAC_W'(0)})
                      + AC_W'(prod_b_q) + AC_W'(32768);
  assign gain_d     = acc[psd_pkg::GAIN_W+psd_pkg::FRAC_W-1:psd_pkg::FRAC_W];
  assign rounded    = {1'b0, gain_d} + (psd_pkg::GAIN_W+1)'(32768);
  assign level_wide = rounded[psd_pkg::GAIN_W:psd_pkg::FRAC_W];
  assign level_d    = (level_wide > 8'(psd_pkg::LEVEL_MAX)) ? psd_pkg::LEVEL_MAX
                                                          : level_wide[psd_pkg::LEVEL_W-1:0];

  always_comb begin
    prev_valid_d = prev_valid_q;
    if (cfg_i.sel_wr) begin
      prev_valid_d = 1'b0;
    end else if (cmd_i.step_en) begin
      prev_valid_d = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.sum_en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_step_q  <= '0;
      prev_valid_q <= 1'b0;
      gain_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      prev_valid_q <= prev_valid_d;
      out_valid_q  <= out_valid_d;
      if (cmd_i.step_en) begin
        prev_step_q <= step_d;
      end
      if (cmd_i.sum_en) begin
        gain_q <= gain_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      frac_q  <= frac_i;
      depth_q <= depth_i;
      sheer_q <= sheer_i;
    end
    if (cmd_i.step_en) begin
      step_q  <= step_d;
      alpha_q <= psd_pkg::ALPHA_TABLE[sheer_q];
    end
    if (cmd_i.mul_en) begin
      prod_a_q <= PA_W'(alpha_q) * PA_W'(target);
      prod_b_q <= PB_W'(psd_pkg::ALPHA_ONE - (psd_pkg::ALPHA_W+1)'(alpha_q)) * PB_W'(gain_q);
    end
    // hold the output word while it waits, even as the next word is stepped
    if (cmd_i.sum_en) begin
      level_q    <= level_d;
      step_out_q <= psd_pkg::STEP_OUT_W'(step_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign step_o      = step_out_q;

endmodule

FILE: rtl/pattern_sidechain_ducker.sv
// Top level of the pattern sidechain ducker: stream ports, APB register port,
// sequencer and datapath. Depends on psd_pkg, psd_regs, psd_ctrl, psd_dpath.

// Each input word carries the phase within the quantum, a ducking depth and a
// slope selector. The block derives the pattern step (4*STEP_COUNT steps per
// quantum, taken modulo STEP_COUNT, with a one-step lead); when the step
// changes, or after reset or a write to the pattern select register, the gate
// bit of the active pattern picks a target of 127 (gate on) or 127-depth (gate
// off), the smoothed Q7.16 level moves toward it by a sheer-dependent alpha,
// and one output word carries the rounded level and the step. A word whose
// step equals the previous one, or that arrives while the selected pattern is
// not present, gives no output. A word that produces a level passes through
// capture, step and alpha lookup, the two blend multiplies and the accumulate
// into the level register before the next word is accepted; a word without
// output returns to idle after the step. The output word sits in its own
// register, so the sum cycle only waits when an earlier output word has not
// yet been taken. Registers: 0x00 pattern select, 0x04..0x10 pattern words
// 0..3 (bit n = step n).
module pattern_sidechain_ducker #(
  parameter int unsigned STEP_COUNT    = 16,
  parameter int unsigned PATTERN_COUNT = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // stream in
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] phase_fraction, [22:16] duck_depth, [29:23] slope_sheer
  input  logic [psd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // stream out
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [6:0] gain_level, [10:7] step_number
  output logic [psd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // APB configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [psd_pkg::ADDR_W-1:0]          paddr,
  input  logic [psd_pkg::DATA_W-1:0]          pwdata,
  output logic [psd_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

  psd_pkg::cfg_t                      cfg;
  psd_pkg::cmd_t                      cmd;
  psd_pkg::status_t                   status;
  logic [psd_pkg::LEVEL_W-1:0]        level;
  logic [psd_pkg::STEP_OUT_W-1:0]     step_num;

  psd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  psd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  psd_dpath #(
    .STEP_COUNT    (STEP_COUNT),
    .PATTERN_COUNT (PATTERN_COUNT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_i       (cfg),
    .frac_i      (s_axis_tdata[15:0]),
    .depth_i     (s_axis_tdata[22:16]),
    .sheer_i     (s_axis_tdata[29:23]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .level_o     (level),
    .step_o      (step_num)
  );

  // pack output word, zero the spare bits
  assign m_axis_tdata = {5'b0, step_num, level};

  // An accepted word keeps the input closed for at least the next cycle
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input open right after accepting a word");

  // A new output word only appears from the sum cycle of a busy sequence
  a_out_from_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("output word appeared while idle");

  // At most one datapath command per cycle
  a_cmd_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_in, cmd.step_en, cmd.mul_en, cmd.sum_en}))
    else $error("overlapping datapath commands");

  // Never overwrite an output word that has not been taken
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sum_en |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output word overwritten");

endmodule

FILE: tb/pattern_sidechain_ducker_tb.sv
// Self-checking testbench of the pattern sidechain ducker.
// Drives tick words and APB register writes, predicts each level word in SV
// and compares it with the output stream. Depends on psd_pkg and the RTL.
module pattern_sidechain_ducker_tb;
  import psd_pkg::*;

  // Step grid of the block as instantiated (default parameters)
  localparam int unsigned STEPS    = 16;
  localparam int unsigned PATTERNS = 4;

  // Run length and timing budget
  localparam int unsigned CYCLE_LIMIT         = 400000;
  localparam int unsigned SETTLE_CYCLES       = 10;
  localparam int unsigned BACKPRESSURE_CYCLES = 160;
  localparam int unsigned RANDOM_PHASES       = 6;
  localparam int unsigned TICKS_PER_PHASE     = 190;

  // Addresses past the register map; writes there must be ignored
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [STEP_OUT_W-1:0] step;
    logic [LEVEL_W-1:0]    level;
  } gain_word_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  // [15:0] phase_fraction, [22:16] duck_depth, [29:23] slope_sheer
  logic [IN_TDATA_W-1:0]    s_axis_tdata  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // [6:0] gain_level, [10:7] step_number
  logic [OUT_TDATA_W-1:0]   m_axis_tdata;
  logic                     psel          = 1'b0;
  logic                     penable       = 1'b0;
  logic                     pwrite        = 1'b0;
  logic [ADDR_W-1:0]        paddr         = '0;
  logic [DATA_W-1:0]        pwdata        = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  // Shared run state
  gain_word_t  expected_gains [$];
  gain_word_t  popped_gain;
  int unsigned errors        = 0;
  int unsigned cycle_count   = 0;
  bit          steady        = 1'b0;  // no idling on either side while set
  bit          long_hold_req = 1'b0;  // ask the sink for one long stall

  // Predictor copy of the block's registers and state
  logic [SEL_W-1:0]  gain_select      = '0;
  logic [WORD_W-1:0] gate_words [PATTERN_SLOTS] = '{default: '0};
  logic [3:0]        last_step        = '0;
  bit                step_seen        = 1'b0;
  logic [GAIN_W-1:0] smoothed_level   = '0;

  pattern_sidechain_ducker DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Bound the run; a stuck handshake or a missing word ends up here
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Q16 smoothing factor, piecewise linear in sheer, rounded to nearest
  function automatic longint unsigned slope_alpha(input logic [6:0] sheer);
    longint unsigned s;
    s = sheer;
    if (s < 32) begin
      return (65536 * (32 + 9 * s) + 1600) / 3200;
    end else if (s < 96) begin
      return (65536 * (64 + 3 * (s - 32)) + 320) / 640;
    end
    return (65536 * (1240 + 59 * (s - 96)) + 1550) / 3100;
  endfunction

  // Advance the predictor by one tick; return 1 when a level word is due
  function automatic bit predict_gain(input logic [15:0] frac, input logic [6:0] depth,
                                      input logic [6:0] sheer, output gain_word_t word);
    longint unsigned f;
    longint unsigned target;
    longint unsigned alpha;
    longint unsigned acc;
    longint unsigned rounded;
    logic [3:0]      step;
    logic            gate;
    f = frac;
    step = 4'((((4 * STEPS * f) >> 16) + 1) % STEPS);
    word = '0;
    if (step_seen && step == last_step) return 1'b0;
    last_step = step;
    step_seen = 1'b1;
    if (gain_select >= PATTERNS) return 1'b0;
    gate   = gate_words[gain_select][step];
    target = gate ? LEVEL_MAX : LEVEL_MAX - depth;
    alpha  = slope_alpha(sheer);
    acc    = alpha * (target << 16) + (65536 - alpha) * smoothed_level + 32768;
    smoothed_level = GAIN_W'(acc >> 16);
    rounded = (smoothed_level + 32768) >> 16;
    if (rounded > LEVEL_MAX) rounded = LEVEL_MAX;
    word.level = LEVEL_W'(rounded);
    word.step  = step;
    return 1'b1;
  endfunction

  // Lowest phase fraction that lands on a given step
  function automatic logic [15:0] frac_for_step(input int unsigned n);
    return 16'(((n + STEPS - 1) % STEPS) * (65536 / (4 * STEPS)));
  endfunction

  function automatic logic [WORD_W-1:0] reg_model(input logic [IDX_W-1:0] idx);
    case (idx)
      REG_SEL:   return WORD_W'(gain_select);
      REG_WORD0,
      REG_WORD1,
      REG_WORD2,
      REG_WORD3: return gate_words[idx - REG_WORD0];
      default:   return '0;
    endcase
  endfunction

  // Offer one tick word after a random gap and hold it until taken.
  // Valid is only dropped ahead of a gap, never in the step it rises again.
  task automatic send_tick(input logic [15:0] frac, input logic [6:0] depth,
                           input logic [6:0] sheer);
    int unsigned gap;
    gain_word_t  word;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, sheer, depth, frac};
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_gain(frac, depth, sheer, word)) expected_gains.push_back(word);
  endtask

  // Stop offering, wait for every pending level word, then let the block
  // finish any tick that had no output before touching registers
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_gains.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One APB transfer: setup phase, access phase until pready, then idle with psel low
  task automatic apb_xfer(input logic wr, input logic [IDX_W-1:0] idx,
                          input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic reg_check(input logic [IDX_W-1:0] idx);
    logic [DATA_W-1:0] rd;
    logic [WORD_W-1:0] got;
    apb_xfer(1'b0, idx, '0, rd);
    got = (idx == REG_SEL) ? WORD_W'(rd[SEL_W-1:0]) : rd[WORD_W-1:0];
    if (got !== reg_model(idx)) begin
      errors++;
      $display("%0t: register %0d read expected %h actual %h", $time, idx, reg_model(idx), got);
    end
  endtask

  task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] unused;
    apb_xfer(1'b1, idx, value, unused);
    case (idx)
      REG_SEL: begin
        gain_select = value[SEL_W-1:0];
        step_seen   = 1'b0;
      end
      REG_WORD0,
      REG_WORD1,
      REG_WORD2,
      REG_WORD3: gate_words[idx - REG_WORD0] = value[WORD_W-1:0];
      default: ;
    endcase
    if (idx <= REG_WORD3) reg_check(idx);
  endtask

  // Output side: random stall per word, or one long hold when asked
  initial begin : result_sink
    int unsigned hold;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (BACKPRESSURE_CYCLES) @(posedge clk_i);
      end else begin
        hold = steady ? 0 : $urandom_range(0, 7);
        if (hold > 0) begin
          m_axis_tready <= 1'b0;
          repeat (hold) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Compare every taken level word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_gains.size() == 0) begin
        errors++;
        $display("%0t: output word %h with nothing expected", $time, m_axis_tdata);
      end else begin
        popped_gain = expected_gains.pop_front();
        if (m_axis_tdata[LEVEL_W-1:0] !== popped_gain.level) begin
          errors++;
          $display("%0t: gain_level expected %0d actual %0d", $time, popped_gain.level,
                   m_axis_tdata[LEVEL_W-1:0]);
        end
        if (m_axis_tdata[LEVEL_W+STEP_OUT_W-1:LEVEL_W] !== popped_gain.step) begin
          errors++;
          $display("%0t: step_number expected %0d actual %0d", $time, popped_gain.step,
                   m_axis_tdata[LEVEL_W+STEP_OUT_W-1:LEVEL_W]);
        end
      end
    end
  end

  // Registers come up zero; the first tick always updates, a repeat does not
  task automatic test_reset_state();
    for (int i = REG_SEL; i <= REG_WORD3; i++) reg_check(IDX_W'(i));
    send_tick(16'h0000, 7'd127, 7'd0);    // full duck with the slowest slope
    send_tick(16'hFFFF, 7'd0, 7'd127);    // top of the quantum wraps to step 0
    send_tick(16'hFC00, 7'd64, 7'd64);    // still step 0, no word
    drain_results();
  endtask

  // Walk all four patterns; a select write forces an update on a repeated step
  task automatic test_gate_patterns();
    reg_write(REG_WORD0, 32'hFFFF_FFFF);
    reg_write(REG_WORD1, 32'hFFFF_0000);
    reg_write(REG_WORD2, 32'h0000_AAAA);
    reg_write(REG_WORD3, 32'h1234_5555);
    for (int sel = 0; sel < PATTERNS; sel++) begin
      drain_results();
      reg_write(REG_SEL, 32'hFFFF_FFFC | DATA_W'(sel));
      send_tick(frac_for_step(4 * sel), 7'd100, 7'd127);
      send_tick(frac_for_step(4 * sel + 1), 7'd100, 7'd127);
      send_tick(frac_for_step(4 * sel + 1), 7'd3, 7'd5);
    end
    drain_results();
    reg_write(REG_SEL, 32'h0000_0003);
    send_tick(frac_for_step(13), 7'd127, 7'd96);
    drain_results();
  endtask

  // Hit both ends of every alpha segment
  task automatic test_slope_segments();
    logic [6:0] sheers [6];
    sheers = '{7'd0, 7'd31, 7'd32, 7'd95, 7'd96, 7'd127};
    for (int k = 0; k < 6; k++) begin
      send_tick(frac_for_step(k), k[0] ? 7'd0 : 7'd127, sheers[k]);
    end
    drain_results();
  endtask

  // Writes past the map must leave every register and the step history alone
  task automatic test_spare_registers();
    reg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
    reg_write(REG_SPARE_HI, 32'h5A5A_5A5A);
    for (int i = REG_SEL; i <= REG_WORD3; i++) reg_check(IDX_W'(i));
    send_tick(frac_for_step(5), 7'd90, 7'd40);   // same step as before, no word
    send_tick(frac_for_step(10), 7'd90, 7'd40);
    drain_results();
  endtask

  // Hold the output off for a long stretch while ticks keep coming back to
  // back, so the output register fills and the input stalls
  task automatic test_output_backpressure();
    steady        = 1'b1;
    long_hold_req = 1'b1;
    for (int n = 0; n < 24; n++) begin
      send_tick(frac_for_step(n), 7'($urandom), 7'($urandom));
    end
    drain_results();
    steady = 1'b0;
  endtask

  // Mostly runs of advancing phase like a real transport clock, some noise
  task automatic test_random_ticks();
    logic [15:0] phase_acc;
    logic [6:0]  depth;
    logic [6:0]  sheer;
    int unsigned run_left;
    phase_acc = '0;
    depth     = '0;
    sheer     = '0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      steady = (p == 3);
      for (int w = 0; w < PATTERN_SLOTS; w++) begin
        case (p)
          0:       reg_write(IDX_W'(REG_WORD0 + w), 32'h0000_0000);
          1:       reg_write(IDX_W'(REG_WORD0 + w), 32'h0000_FFFF);
          default: reg_write(IDX_W'(REG_WORD0 + w), $urandom);
        endcase
      end
      case (p)
        0:       reg_write(REG_SEL, 32'd0);
        1:       reg_write(REG_SEL, 32'd3);
        default: reg_write(REG_SEL, $urandom);
      endcase
      run_left = 0;
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        if (run_left == 0) begin
          if ($urandom_range(0, 4) == 0) begin
            send_tick(16'($urandom), 7'($urandom), 7'($urandom));
            continue;
          end
          run_left  = $urandom_range(4, 32);
          phase_acc = 16'($urandom);
          depth     = 7'($urandom);
          sheer     = 7'($urandom);
        end
        // Step width is 1024, so some advances stay on the same step
        phase_acc += 16'($urandom_range(0, 1536));
        if ($urandom_range(0, 7) == 0) depth = 7'($urandom);
        if ($urandom_range(0, 7) == 0) sheer = 7'($urandom);
        send_tick(phase_acc, depth, sheer);
        run_left--;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);
    test_reset_state();
    test_gate_patterns();
    test_slope_segments();
    test_spare_registers();
    test_output_backpressure();
    test_random_ticks();
    drain_results();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/psd_pkg.sv
rtl/psd_regs.sv
rtl/psd_ctrl.sv
rtl/psd_dpath.sv
rtl/pattern_sidechain_ducker.sv
tb/pattern_sidechain_ducker_tb.sv
